/* rtl/core/ktbl_pkg.sv */
// Shared types and constants of the keyed token bucket limiter.
package ktbl_pkg;

   localparam int NUM_BUCKETS  = 256;
   localparam int BUCKET_W     = $clog2(NUM_BUCKETS);
   localparam int OP_W         = 1;
   localparam int INDEX_W      = 8;
   localparam int TIME_W       = 48;
   localparam int TOKEN_W      = 20;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = 20;
   localparam int ELAPSED_W    = 32;
   localparam int PRODUCT_W    = ELAPSED_W + TOKEN_W;
   localparam int ROOM_W       = 30;
   localparam int RECIP_W      = 31;
   localparam int RECIP_SHIFT  = 40;
   localparam int FQ_DEPTH     = 2;
   localparam int FQ_PTR_W     = $clog2(FQ_DEPTH);
   localparam int FQ_CNT_W     = $clog2(FQ_DEPTH + 1);

   localparam logic [ROOM_W-1:0]    MS_PER_SECOND = ROOM_W'(1000);
   localparam logic [RECIP_W-1:0]   MS_RECIP      = RECIP_W'(1099511628);
   localparam logic [ELAPSED_W-1:0] ELAPSED_MAX   = '1;

   typedef enum logic [OP_W-1:0] {
      OP_ACQUIRE = 1'b0,
      OP_QUERY   = 1'b1
   } ktbl_op_type;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_CAPACITY = 1'b0,
      CSR_REFILL   = 1'b1
   } ktbl_csr_type;

   typedef struct packed {
      ktbl_op_type         op;
      logic [BUCKET_W-1:0] bucket;
      logic [TIME_W-1:0]   now_ms;
   } ktbl_req_type;

   typedef struct packed {
      logic [TOKEN_W-1:0] tokens;
      logic [TIME_W-1:0]  mark_ms;
   } ktbl_entry_type;

endpackage

/* rtl/core/ktbl_ram.sv */
// Generic single-port-write, single-port-read RAM with registered read data.
module ktbl_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

/* rtl/core/ktbl_front.sv */
// Front queue: accepts transactions, decodes the op and wraps the bucket number.
module ktbl_front (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         push,
   output logic                         full,
   input  logic [ktbl_pkg::OP_W-1:0]    req_op,
   input  logic [ktbl_pkg::INDEX_W-1:0] req_bucket_index,
   input  logic [ktbl_pkg::TIME_W-1:0]  req_now_ms,
   output logic                         item_valid,
   output ktbl_pkg::ktbl_req_type       item,
   input  logic                         item_take
);
   import ktbl_pkg::*;

   ktbl_req_type        entry_ff [FQ_DEPTH];
   logic [FQ_PTR_W-1:0] wr_ptr_ff;
   logic [FQ_PTR_W-1:0] rd_ptr_ff;
   logic [FQ_CNT_W-1:0] count_ff;
   logic                accept;
   logic                take;
   ktbl_req_type        decoded;

   assign full       = (count_ff == FQ_CNT_W'(FQ_DEPTH));
   assign item_valid = (count_ff != '0);
   assign item       = entry_ff[rd_ptr_ff];
   assign accept     = push && !full;
   assign take       = item_take && item_valid;

   always_comb begin
      decoded.op     = ktbl_op_type'(req_op);
      decoded.bucket = req_bucket_index[BUCKET_W-1:0];
      decoded.now_ms = req_now_ms;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (accept) begin
            wr_ptr_ff <= wr_ptr_ff + FQ_PTR_W'(1);
         end
         if (take) begin
            rd_ptr_ff <= rd_ptr_ff + FQ_PTR_W'(1);
         end
         if (accept && !take) begin
            count_ff <= count_ff + FQ_CNT_W'(1);
         end else if (take && !accept) begin
            count_ff <= count_ff - FQ_CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         entry_ff[wr_ptr_ff] <= decoded;
      end
   end

endmodule

/* rtl/core/ktbl_back.sv */
// Back engine: bucket table, refill arithmetic, registers and result slot.
module ktbl_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [ktbl_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ktbl_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                             item_valid,
   input  ktbl_pkg::ktbl_req_type           item,
   output logic                             item_take,
   input  logic                             pop,
   output logic                             empty,
   output logic                             rsp_granted,
   output logic                             rsp_retry_after
);
   import ktbl_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE,
      S_ELAPSED,
      S_MUL,
      S_DIV,
      S_WRITE
   } state_type;

   state_type                 state_ff;
   logic [TOKEN_W-1:0]        cap_ff;
   logic [TOKEN_W-1:0]        rate_ff;
   logic [NUM_BUCKETS-1:0]    in_use_ff;
   ktbl_op_type               op_ff;
   logic [BUCKET_W-1:0]       bucket_ff;
   logic [TIME_W-1:0]         now_ff;
   logic                      used_ff;
   logic [TOKEN_W-1:0]        count_ff;
   logic [TIME_W-1:0]         mark_ff;
   logic [ELAPSED_W-1:0]      elapsed_ff;
   logic [PRODUCT_W-1:0]      product_ff;
   logic                      room_pos_ff;
   logic [ROOM_W-1:0]         room_ms_ff;
   logic                      due_ff;
   logic                      fill_ff;
   logic [TOKEN_W-1:0]        quot_ff;
   logic                      rsp_valid_ff;
   logic                      granted_ff;
   logic                      retry_ff;

   ktbl_entry_type            rd_entry;
   ktbl_entry_type            wr_entry;
   logic                      ram_wr_en;
   logic                      slot_free;
   logic [TOKEN_W-1:0]        count_in;
   logic [TIME_W-1:0]         mark_in;
   logic [TIME_W-1:0]         span;
   logic [ELAPSED_W-1:0]      elapsed_in;
   logic [TOKEN_W:0]          room;
   logic [ROOM_W-1:0]         room_ms_in;
   logic [PRODUCT_W-1:0]      product_in;
   logic [ROOM_W+RECIP_W-1:0] recip_prod;
   logic [TOKEN_W-1:0]        quot_in;
   logic                      due_in;
   logic                      fill_in;
   logic [TOKEN_W-1:0]        refilled;
   logic                      granted_in;
   logic                      retry_in;

   assign slot_free = !rsp_valid_ff || pop;
   assign item_take = (state_ff == S_IDLE) && item_valid && slot_free;
   assign ram_wr_en = (state_ff == S_WRITE) && (op_ff == OP_ACQUIRE);

   ktbl_ram #(
      .WIDTH ($bits(ktbl_entry_type)),
      .DEPTH (NUM_BUCKETS)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_wr_en),
      .wr_addr (bucket_ff),
      .wr_data (wr_entry),
      .rd_en   (item_take),
      .rd_addr (item.bucket),
      .rd_data (rd_entry)
   );

   always_comb begin
      count_in   = used_ff ? rd_entry.tokens : cap_ff;
      mark_in    = used_ff ? rd_entry.mark_ms : now_ff;
      span       = now_ff - mark_in;
      if (now_ff <= mark_in) begin
         elapsed_in = '0;
      end else if (span[TIME_W-1:ELAPSED_W] != '0) begin
         elapsed_in = ELAPSED_MAX;
      end else begin
         elapsed_in = span[ELAPSED_W-1:0];
      end
      product_in = PRODUCT_W'(elapsed_ff) * PRODUCT_W'(rate_ff);
      room       = {1'b0, cap_ff} - {1'b0, count_ff};
      room_ms_in = ROOM_W'(room[TOKEN_W-1:0]) * MS_PER_SECOND;
      due_in     = product_ff >= PRODUCT_W'(MS_PER_SECOND);
      fill_in    = !room_pos_ff || (product_ff >= PRODUCT_W'(room_ms_ff));
      recip_prod = (ROOM_W+RECIP_W)'(product_ff[ROOM_W-1:0])
                   * (ROOM_W+RECIP_W)'(MS_RECIP);
      quot_in    = recip_prod[RECIP_SHIFT+TOKEN_W-1:RECIP_SHIFT];
      if (!due_ff) begin
         refilled = count_ff;
      end else if (fill_ff) begin
         refilled = cap_ff;
      end else begin
         refilled = count_ff + quot_ff;
      end
      granted_in      = (op_ff == OP_ACQUIRE) && (refilled != '0);
      retry_in        = (op_ff == OP_QUERY) && used_ff && !due_ff;
      wr_entry.tokens = refilled - TOKEN_W'(granted_in);
      wr_entry.mark_ms = due_ff ? now_ff : mark_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff <= TOKEN_W'(100);
         rate_ff <= TOKEN_W'(10);
      end else if (csr_wr_en) begin
         case (ktbl_csr_type'(csr_index))
            CSR_CAPACITY: cap_ff  <= csr_wdata;
            CSR_REFILL:   rate_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_use_ff <= '0;
      end else if (ram_wr_en) begin
         in_use_ff[bucket_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (pop && rsp_valid_ff) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            S_IDLE: begin
               if (item_take) begin
                  op_ff     <= item.op;
                  bucket_ff <= item.bucket;
                  now_ff    <= item.now_ms;
                  used_ff   <= in_use_ff[item.bucket];
                  state_ff  <= S_ELAPSED;
               end
            end
            S_ELAPSED: begin
               count_ff   <= count_in;
               mark_ff    <= mark_in;
               elapsed_ff <= elapsed_in;
               state_ff   <= S_MUL;
            end
            S_MUL: begin
               product_ff  <= product_in;
               room_pos_ff <= !room[TOKEN_W] && (room != '0);
               room_ms_ff  <= room_ms_in;
               state_ff    <= S_DIV;
            end
            S_DIV: begin
               due_ff   <= due_in;
               fill_ff  <= fill_in;
               quot_ff  <= quot_in;
               state_ff <= S_WRITE;
            end
            S_WRITE: begin
               rsp_valid_ff <= 1'b1;
               granted_ff   <= granted_in;
               retry_ff     <= retry_in;
               state_ff     <= S_IDLE;
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign empty           = !rsp_valid_ff;
   assign rsp_granted     = granted_ff;
   assign rsp_retry_after = retry_ff;

   a_slot_not_overwritten: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRITE) |-> !rsp_valid_ff)
      else $error("result slot overwritten");

   a_one_answer: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(granted_ff && retry_ff))
      else $error("grant and retry both set");

   a_bucket_marked: assert property (@(posedge clock) disable iff (reset)
      ram_wr_en |=> in_use_ff[bucket_ff])
      else $error("acquired bucket not marked in use");

   a_partial_refill_fits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRITE && due_ff && !fill_ff)
      |-> (({1'b0, count_ff} + {1'b0, quot_ff}) < {1'b0, cap_ff}))
      else $error("partial refill reaches capacity");

endmodule

/* rtl/core/keyed_token_bucket_limiter_unit.sv */
// Each transaction passes through the back engine in order: one read of the
// bucket memory, the elapsed-time subtract, the elapsed-by-rate multiply, the
// divide by 1000 as a reciprocal multiply, and the write back, one bucket at a
// time through the bucket memory; a two-entry front queue keeps taking
// transactions meanwhile, and one result slot holds the answer until popped.
// The 256 buckets start unused after reset through flip-flop in-use bits, so
// no clearing pass is needed. Registers: index 0 bucket capacity, index 1
// refill tokens per second; write them only while no transaction is pending.
module keyed_token_bucket_limiter_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_wr_en,
   input  logic [ktbl_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [ktbl_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  logic                             push,
   output logic                             full,
   input  logic [ktbl_pkg::OP_W-1:0]        req_op,
   input  logic [ktbl_pkg::INDEX_W-1:0]     req_bucket_index,
   input  logic [ktbl_pkg::TIME_W-1:0]      req_now_ms,
   output logic                             empty,
   input  logic                             pop,
   output logic                             rsp_granted,
   output logic                             rsp_retry_after
);
   import ktbl_pkg::*;

   logic         item_valid;
   logic         item_take;
   ktbl_req_type item;

   ktbl_front u_front (
      .clock            (clock),
      .reset            (reset),
      .push             (push),
      .full             (full),
      .req_op           (req_op),
      .req_bucket_index (req_bucket_index),
      .req_now_ms       (req_now_ms),
      .item_valid       (item_valid),
      .item             (item),
      .item_take        (item_take)
   );

   ktbl_back u_back (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .item_valid      (item_valid),
      .item            (item),
      .item_take       (item_take),
      .pop             (pop),
      .empty           (empty),
      .rsp_granted     (rsp_granted),
      .rsp_retry_after (rsp_retry_after)
   );

endmodule
